### src/celb_pkg.sv
// Package for the cursor line edit buffer: key codes, key classes,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
package celb_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 8;
  localparam int unsigned CHAR_W       = 7;

  localparam logic [KEY_W-1:0] KEY_NEWLINE = 8'd10;
  localparam logic [KEY_W-1:0] KEY_BACK    = 8'd45;
  localparam logic [KEY_W-1:0] KEY_LEFT    = 8'd60;
  localparam logic [KEY_W-1:0] KEY_RIGHT   = 8'd62;

  typedef enum logic [2:0] {
    KC_OTHER,
    KC_NEWLINE,
    KC_BACK,
    KC_LEFT,
    KC_RIGHT,
    KC_INSERT
  } key_class_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE_L,
    S_MOVE_R,
    S_RD,
    S_LOAD,
    S_EMPTY
  } ctrl_state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_BACK,
    OP_SHIFT_L,
    OP_SHIFT_R,
    OP_EMIT_START,
    OP_EMIT_LOAD,
    OP_EMIT_EMPTY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   emit;
  } dp_cmd_t;

  typedef struct packed {
    logic lc_zero;
    logic rc_zero;
    logic lc_max;
    logic rc_max;
    logic buf_full;
    logic buf_empty;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  function automatic key_class_e classify_key(input logic [KEY_W-1:0] k);
    key_class_e c;
    case (k) inside
      KEY_NEWLINE:                                   c = KC_NEWLINE;
      KEY_BACK:                                      c = KC_BACK;
      KEY_LEFT:                                      c = KC_LEFT;
      KEY_RIGHT:                                     c = KC_RIGHT;
      [8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]: c = KC_INSERT;
      default:                                       c = KC_OTHER;
    endcase
    return c;
  endfunction

endpackage

### src/cursor_line_edit_buffer.sv
// Top level of the cursor line edit buffer: controller and datapath.
// Depends on celb_pkg, celb_ctrl, celb_dp and celb_ram.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, key_code_i       | request in
//   out     | out_valid_o, out_stall_i, char_code_o,   | request out
//           | last_o, empty_res_o                      |
//
// Insert, backspace and ignored keys are handled in the idle state without stalling input; a cursor move
// stalls input for a stack RAM read, then a write to the other stack.
// A newline starts emission, then per character a RAM read and an output
// register load; an empty line loads the empty result. Input stalls during moves and emission.
// Reset clears both counts; no clearing pass, as stack RAM data above the counts is
// never used. A stalled output holds emission at the load step.
module cursor_line_edit_buffer #(
  parameter int unsigned CAPACITY = celb_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] char_code_o,
  output logic       last_o,
  output logic       empty_res_o
);

  import celb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  celb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .key_code_i (key_code_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  celb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_code_i  (key_code_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule

### src/celb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module celb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/celb_ctrl.sv
// Controller for the cursor line edit buffer: decodes keys and sequences
// stack moves and line emission. Depends on celb_pkg.
module celb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            key_code_i,
  input  celb_pkg::dp_status_t  status_i,
  output celb_pkg::dp_cmd_t     cmd_o
);

  import celb_pkg::*;

  ctrl_state_e state_q, state_d;
  key_class_e  kc;

  assign kc = classify_key(key_code_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_HOLD;
    cmd_o.emit  = 1'b0;
    in_stall_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kc)
            KC_NEWLINE: begin
              if (status_i.buf_empty) begin
                state_d = S_EMPTY;
              end else begin
                cmd_o.op = OP_EMIT_START;
                state_d  = S_RD;
              end
            end
            KC_BACK: begin
              if (!status_i.lc_zero) cmd_o.op = OP_BACK;
            end
            KC_LEFT: begin
              if (!status_i.lc_zero && !status_i.rc_max) state_d = S_MOVE_L;
            end
            KC_RIGHT: begin
              if (!status_i.rc_zero && !status_i.lc_max) state_d = S_MOVE_R;
            end
            KC_INSERT: begin
              if (!status_i.buf_full) cmd_o.op = OP_INSERT;
            end
            default: ;
          endcase
        end
      end
      S_MOVE_L: begin
        cmd_o.op = OP_SHIFT_L;
        state_d  = S_IDLE;
      end
      S_MOVE_R: begin
        cmd_o.op = OP_SHIFT_R;
        state_d  = S_IDLE;
      end
      S_RD: begin
        cmd_o.emit = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.emit = 1'b1;
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT_LOAD;
          state_d  = status_i.emit_last ? S_IDLE : S_RD;
        end
      end
      S_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT_EMPTY;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### src/celb_dp.sv
// Datapath for the cursor line edit buffer: the two stack RAMs, their counts,
// the emission index and the output register. Depends on celb_pkg and celb_ram.
module celb_dp #(
  parameter int unsigned CAPACITY = celb_pkg::CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            key_code_i,
  input  celb_pkg::dp_cmd_t     cmd_i,
  output celb_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [6:0]            char_code_o,
  output logic                  last_o,
  output logic                  empty_res_o
);

  import celb_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic [CW-1:0]     lc_q, lc_d, rc_q, rc_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     idx_ext, total, lc_m1, rc_m1, rev_idx, total_m1;
  logic              emit_from_left;

  logic              left_we, right_we;
  logic [AW-1:0]     left_waddr, right_waddr, left_raddr, right_raddr;
  logic [CHAR_W-1:0] left_wdata, right_wdata, left_rdata, right_rdata;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d, empty_q, empty_d;
  logic              out_free;

  assign idx_ext  = CW'(idx_q);
  assign total    = lc_q + rc_q;
  assign total_m1 = total - CW'(1);
  assign lc_m1    = lc_q - CW'(1);
  assign rc_m1    = rc_q - CW'(1);
  assign rev_idx  = total_m1 - idx_ext;
  assign emit_from_left = (idx_ext < lc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.lc_zero   = (lc_q == '0);
  assign status_o.rc_zero   = (rc_q == '0);
  assign status_o.lc_max    = (lc_q == CW'(CAPACITY));
  assign status_o.rc_max    = (rc_q == CW'(CAPACITY));
  assign status_o.buf_full  = (total == CW'(CAPACITY));
  assign status_o.buf_empty = (total == '0);
  assign status_o.emit_last = (idx_ext == total_m1);
  assign status_o.out_free  = out_free;

  assign left_raddr  = cmd_i.emit ? idx_q : lc_m1[AW-1:0];
  assign right_raddr = cmd_i.emit ? rev_idx[AW-1:0] : rc_m1[AW-1:0];

  always_comb begin
    left_we     = 1'b0;
    right_we    = 1'b0;
    left_waddr  = lc_q[AW-1:0];
    right_waddr = rc_q[AW-1:0];
    left_wdata  = key_code_i[CHAR_W-1:0];
    right_wdata = left_rdata;
    lc_d        = lc_q;
    rc_d        = rc_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    empty_d     = empty_q;
    case (cmd_i.op)
      OP_INSERT: begin
        left_we = 1'b1;
        lc_d    = lc_q + CW'(1);
      end
      OP_BACK: begin
        lc_d = lc_m1;
      end
      OP_SHIFT_L: begin
        right_we = 1'b1;
        lc_d     = lc_m1;
        rc_d     = rc_q + CW'(1);
      end
      OP_SHIFT_R: begin
        left_we    = 1'b1;
        left_wdata = right_rdata;
        rc_d       = rc_m1;
        lc_d       = lc_q + CW'(1);
      end
      OP_EMIT_START: begin
        idx_d = '0;
      end
      OP_EMIT_LOAD: begin
        out_valid_d = 1'b1;
        char_d      = emit_from_left ? left_rdata : right_rdata;
        last_d      = status_o.emit_last;
        empty_d     = 1'b0;
        idx_d       = idx_q + AW'(1);
        if (status_o.emit_last) begin
          lc_d = '0;
          rc_d = '0;
        end
      end
      OP_EMIT_EMPTY: begin
        out_valid_d = 1'b1;
        char_d      = '0;
        last_d      = 1'b1;
        empty_d     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q        <= '0;
      rc_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      lc_q        <= lc_d;
      rc_q        <= rc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  celb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (left_wdata),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  celb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (right_wdata),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule
